/* rtl/core/rfdt_pkg.sv */
// Shared types, codes and constants for the receive deframer with timestamp.
// Used by every module under rtl/core; depends on nothing else.
package rfdt_pkg;

  // Default values for the top-level parameters.
  localparam int HEADER_BYTES_DEF      = 14;
  localparam int REF_CLOCK_HZ_DEF      = 125000000;
  localparam int REF_PERIOD_PS_DEF     = 8000;
  localparam int MAX_PAYLOAD_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF       = 8;

  // FIFO word tags.
  localparam logic [1:0] WORD_DATA   = 2'd0;
  localparam logic [1:0] WORD_OOB    = 2'd1;
  localparam logic [1:0] WORD_STATUS = 2'd2;
  localparam logic [1:0] WORD_BSEL   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // Register map: word index taken from paddr[2].
  localparam logic REG_PAYLOAD_BUFFER = 1'b0;

  localparam logic [11:0] BUF_BYTES_RESET = 12'd1536;
  localparam logic [15:0] OOB_FLAG_RESET  = 16'h0800;
  localparam int          TS_BAD_BIT      = 11;
  localparam logic [29:0] QUARTER_SEC_NS  = 30'd250000000;
  localparam logic [30:0] NS_MAX          = 31'h7FFFFFFF;

  typedef struct packed {
    logic [1:0]  word_type;
    logic [15:0] word_data;
    logic        fifo_empty;
    logic [39:0] now_seconds;
    logic [29:0] now_nanoseconds;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [9:0]  word_index;
    logic [15:0] stored_word;
    logic [11:0] frame_bytes;
    logic [39:0] stamp_seconds;
    logic [30:0] stamp_nanoseconds;
    logic        stamp_ahead;
    logic        stamp_valid;
    logic        last_of_run;
  } result_t;

  // Up to two results produced by one word, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* rtl/core/rx_fabric_deframer_timestamp.sv */
// Top level of the receive deframer with timestamp: input register, APB
// register, deframing logic and result queue. Depends on rfdt_pkg,
// rfdt_deframe (with rfdt_stamp) and rfdt_queue.
//
//   Channel  Direction  Handshake          Beat contents
//   in_      input      in_valid/in_ready  one receive FIFO word plus current time
//   out_     output     out_valid/out_ready one header store, payload store or frame done
//   APB      input      psel/penable       payload buffer size register at byte address 0
//
// A word is registered at the edge it is accepted and evaluated in the next
// cycle, where its results (none, one or two) enter the result queue at the
// following edge; out_valid comes from the registered queue count, so a result
// can be taken only once it is held in the queue. One word can be accepted
// every cycle while in_ready is high; the sustained rate is set by the output
// side, one result per beat, so words that cause two results draw two beats.
// Reset (rst_n low at a clock edge) clears the frame state, empties the
// queue and loads the buffer size with 1536 bytes.
// in_ready drops only when the queue cannot take the results of the word
// in the input register plus those of one more word; a stalled out_ready
// therefore backs up into the input and nothing is lost.
module rx_fabric_deframer_timestamp #(
  parameter int HEADER_BYTES      = rfdt_pkg::HEADER_BYTES_DEF,
  parameter int REF_CLOCK_HZ      = rfdt_pkg::REF_CLOCK_HZ_DEF,
  parameter int REF_PERIOD_PS     = rfdt_pkg::REF_PERIOD_PS_DEF,
  parameter int MAX_PAYLOAD_BYTES = rfdt_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int QUEUE_DEPTH       = rfdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_word_type,
  input  logic [15:0] in_word_data,
  input  logic        in_fifo_empty,
  input  logic [39:0] in_now_seconds,
  input  logic [29:0] in_now_nanoseconds,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [9:0]  out_word_index,
  output logic [15:0] out_stored_word,
  output logic [11:0] out_frame_bytes,
  output logic [39:0] out_stamp_seconds,
  output logic [30:0] out_stamp_nanoseconds,
  output logic        out_stamp_ahead,
  output logic        out_stamp_valid,
  output logic        out_last_of_run
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [11:0]       buf_bytes_r, buf_bytes_nxt;
  logic              s1_valid_r;
  rfdt_pkg::item_t   s1_item_r;
  rfdt_pkg::push_t   push;
  rfdt_pkg::result_t head;
  logic [CW-1:0]     q_count;
  logic [CW:0]       q_claim;
  logic              in_fire;
  logic              cfg_write;

  // Configuration register. Writes land in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    buf_bytes_nxt = buf_bytes_r;
    if (cfg_write && paddr[2] == rfdt_pkg::REG_PAYLOAD_BUFFER) begin
      buf_bytes_nxt = pwdata[11:0];
    end
  end

  assign prdata = (paddr[2] == rfdt_pkg::REG_PAYLOAD_BUFFER) ? {20'b0, buf_bytes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_bytes_r <= rfdt_pkg::BUF_BYTES_RESET;
    end else begin
      buf_bytes_r <= buf_bytes_nxt;
    end
  end

  // Room is reserved for two results from the registered word and two from
  // the word being accepted.
  assign q_claim  = {1'b0, q_count} + (s1_valid_r ? (CW+1)'(2) : '0);
  assign in_ready = (q_claim <= (CW+1)'(QUEUE_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.word_type       <= in_word_type;
      s1_item_r.word_data       <= in_word_data;
      s1_item_r.fifo_empty      <= in_fifo_empty;
      s1_item_r.now_seconds     <= in_now_seconds;
      s1_item_r.now_nanoseconds <= in_now_nanoseconds;
    end
  end

  rfdt_deframe #(
    .HEADER_BYTES      (HEADER_BYTES),
    .REF_CLOCK_HZ      (REF_CLOCK_HZ),
    .REF_PERIOD_PS     (REF_PERIOD_PS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_deframe (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .buf_bytes  (buf_bytes_r),
    .push       (push)
  );

  rfdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign out_result_kind       = head.result_kind;
  assign out_word_index        = head.word_index;
  assign out_stored_word       = head.stored_word;
  assign out_frame_bytes       = head.frame_bytes;
  assign out_stamp_seconds     = head.stamp_seconds;
  assign out_stamp_nanoseconds = head.stamp_nanoseconds;
  assign out_stamp_ahead       = head.stamp_ahead;
  assign out_stamp_valid       = head.stamp_valid;
  assign out_last_of_run       = head.last_of_run;

endmodule

/* rtl/core/rfdt_stamp.sv */
// Converts the raw out-of-band counter stamp and the current time into the
// frame timestamp fields. Combinational; depends on rfdt_pkg.
module rfdt_stamp #(
  parameter int REF_CLOCK_HZ  = rfdt_pkg::REF_CLOCK_HZ_DEF,
  parameter int REF_PERIOD_PS = rfdt_pkg::REF_PERIOD_PS_DEF
) (
  input  logic        present,
  input  logic [31:0] raw_stamp,
  input  logic [15:0] flag_word,
  input  logic [39:0] now_seconds,
  input  logic [29:0] now_nanoseconds,
  output logic [39:0] stamp_seconds,
  output logic [30:0] stamp_nanoseconds,
  output logic        stamp_ahead,
  output logic        stamp_valid
);

  localparam int          NS_PER_TICK = REF_PERIOD_PS / 1000;
  localparam logic [9:0]  TICK_NS     = 10'(NS_PER_TICK);
  localparam logic [28:0] ROLL_TICKS  = 29'((64'(3) * 64'(REF_CLOCK_HZ)) / 64'(4));

  logic [27:0] rise;
  logic [3:0]  fall;
  logic [37:0] product;
  logic        rollback;

  assign rise    = raw_stamp[27:0];
  assign fall    = raw_stamp[31:28];
  assign product = {10'b0, rise} * {28'b0, TICK_NS};

  // A late rising count sampled early in the next second belongs to the
  // previous second.
  assign rollback = ({1'b0, rise} > ROLL_TICKS) &&
                    (now_nanoseconds < rfdt_pkg::QUARTER_SEC_NS) &&
                    (now_seconds != 40'd0);

  always_comb begin
    stamp_seconds     = 40'd0;
    stamp_nanoseconds = 31'd0;
    stamp_ahead       = 1'b0;
    stamp_valid       = 1'b0;
    if (present) begin
      stamp_seconds     = rollback ? now_seconds - 40'd1 : now_seconds;
      stamp_nanoseconds = (product > {7'b0, rfdt_pkg::NS_MAX}) ? rfdt_pkg::NS_MAX
                                                              : product[30:0];
      stamp_ahead       = (4'(rise[3:0] - fall) == 4'd1);
      stamp_valid       = !flag_word[rfdt_pkg::TS_BAD_BIT];
    end
  end

endmodule

/* rtl/core/rfdt_queue.sv */
// Result queue: takes up to two results per cycle and hands out one per beat.
// Depends on rfdt_pkg for the result type.
module rfdt_queue #(
  parameter int DEPTH = rfdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rfdt_pkg::push_t            push,
  input  logic                       pop,
  output rfdt_pkg::result_t          head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  rfdt_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_plus1;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
  endfunction

  assign wp_plus1  = ptr_inc(wp_r);
  assign head      = mem_r[rp_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r + CW'(push.count);
    if (push.count == 2'd1) begin
      wp_nxt = wp_plus1;
    end else if (push.count == 2'd2) begin
      wp_nxt = ptr_inc(wp_plus1);
    end
    if (pop && not_empty) begin
      rp_nxt    = ptr_inc(rp_r);
      count_nxt = count_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wp_plus1] <= push.second;
    end
  end

endmodule

/* rtl/core/rfdt_deframe.sv */
// Frame state and per-word decision logic: header and payload stores and the
// frame-done result. Depends on rfdt_pkg and rfdt_stamp.
module rfdt_deframe #(
  parameter int HEADER_BYTES      = rfdt_pkg::HEADER_BYTES_DEF,
  parameter int REF_CLOCK_HZ      = rfdt_pkg::REF_CLOCK_HZ_DEF,
  parameter int REF_PERIOD_PS     = rfdt_pkg::REF_PERIOD_PS_DEF,
  parameter int MAX_PAYLOAD_BYTES = rfdt_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  rfdt_pkg::item_t   item,
  input  logic [11:0]       buf_bytes,
  output rfdt_pkg::push_t   push
);

  localparam int          HW      = $clog2(HEADER_BYTES + 2);
  localparam logic [11:0] MAX_CAP = 12'((MAX_PAYLOAD_BYTES > 4095) ? 4095 : MAX_PAYLOAD_BYTES);

  logic [HW-1:0] hdr_r, hdr_nxt, hdr_new;
  logic [15:0]   pay_r, pay_nxt, pay_new;
  logic [1:0]    oob_r, oob_nxt, oob_new;
  logic [15:0]   flag_r, flag_nxt, flag_new;
  logic [31:0]   raw_r, raw_nxt, raw_new;

  logic [11:0]   buf_use;
  logic [16:0]   pay_plus2;
  logic          store_en, done;
  rfdt_pkg::result_t store_res, done_res;
  logic [39:0]   st_sec;
  logic [30:0]   st_ns;
  logic          st_ahead, st_valid;

  assign buf_use   = (buf_bytes < MAX_CAP) ? buf_bytes : MAX_CAP;
  assign pay_plus2 = {1'b0, pay_r} + 17'd2;

  // Per-word state update; *_new are the values after this word, before any
  // end-of-frame clear.
  always_comb begin
    hdr_new   = hdr_r;
    pay_new   = pay_r;
    oob_new   = oob_r;
    flag_new  = flag_r;
    raw_new   = raw_r;
    store_en  = 1'b0;
    done      = 1'b0;
    store_res = '0;
    if (oob_r != 2'd0) begin
      if (item.word_type == rfdt_pkg::WORD_OOB) begin
        if (oob_r == 2'd1) begin
          raw_new = {item.word_data, 16'h0000};
          oob_new = 2'd2;
        end else begin
          raw_new = raw_r | {16'h0000, item.word_data};
          oob_new = 2'd3;
          done    = 1'b1;
        end
        if (item.fifo_empty) begin
          done = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end else if (item.word_type == rfdt_pkg::WORD_OOB) begin
      flag_new = item.word_data;
      oob_new  = 2'd1;
      done     = item.fifo_empty;
    end else begin
      if (item.word_type == rfdt_pkg::WORD_DATA && hdr_r < HW'(HEADER_BYTES)) begin
        store_en              = 1'b1;
        store_res.result_kind = rfdt_pkg::KIND_HEADER;
        store_res.word_index  = 10'(hdr_r >> 1);
        store_res.stored_word = item.word_data;
        hdr_new               = hdr_r + HW'(2);
      end else if (item.word_type != rfdt_pkg::WORD_STATUS && pay_r >= {4'b0, buf_use}) begin
        // Buffer full: count the bytes but drop the word.
        pay_new = pay_plus2[16] ? 16'hFFFF : pay_plus2[15:0];
      end else if (item.word_type == rfdt_pkg::WORD_DATA ||
                   item.word_type == rfdt_pkg::WORD_BSEL) begin
        store_en              = 1'b1;
        store_res.result_kind = rfdt_pkg::KIND_PAYLOAD;
        store_res.word_index  = pay_r[10:1];
        store_res.stored_word = item.word_data;
        pay_new = pay_r + ((item.word_type == rfdt_pkg::WORD_DATA) ? 16'd2 : 16'd1);
      end else if (hdr_r != '0) begin
        // A status word after the header closes the frame.
        done = 1'b1;
      end
      if (item.fifo_empty) begin
        done = 1'b1;
      end
    end
  end

  rfdt_stamp #(
    .REF_CLOCK_HZ  (REF_CLOCK_HZ),
    .REF_PERIOD_PS (REF_PERIOD_PS)
  ) u_stamp (
    .present           (oob_new != 2'd0),
    .raw_stamp         (raw_new),
    .flag_word         (flag_new),
    .now_seconds       (item.now_seconds),
    .now_nanoseconds   (item.now_nanoseconds),
    .stamp_seconds     (st_sec),
    .stamp_nanoseconds (st_ns),
    .stamp_ahead       (st_ahead),
    .stamp_valid       (st_valid)
  );

  always_comb begin
    done_res                   = '0;
    done_res.result_kind       = rfdt_pkg::KIND_DONE;
    done_res.frame_bytes       = (pay_new < {4'b0, buf_use}) ? pay_new[11:0] : buf_use;
    done_res.stamp_seconds     = st_sec;
    done_res.stamp_nanoseconds = st_ns;
    done_res.stamp_ahead       = st_ahead;
    done_res.stamp_valid       = st_valid;
    done_res.last_of_run       = 1'b1;
  end

  always_comb begin
    push = '0;
    if (item_valid) begin
      if (store_en && done) begin
        push.count              = 2'd2;
        push.first              = store_res;
        push.second             = done_res;
      end else if (store_en) begin
        push.count              = 2'd1;
        push.first              = store_res;
        push.first.last_of_run  = 1'b1;
      end else if (done) begin
        push.count              = 2'd1;
        push.first              = done_res;
      end
    end
  end

  always_comb begin
    hdr_nxt  = hdr_r;
    pay_nxt  = pay_r;
    oob_nxt  = oob_r;
    flag_nxt = flag_r;
    raw_nxt  = raw_r;
    if (item_valid) begin
      if (done) begin
        hdr_nxt  = '0;
        pay_nxt  = '0;
        oob_nxt  = '0;
        flag_nxt = rfdt_pkg::OOB_FLAG_RESET;
        raw_nxt  = '0;
      end else begin
        hdr_nxt  = hdr_new;
        pay_nxt  = pay_new;
        oob_nxt  = oob_new;
        flag_nxt = flag_new;
        raw_nxt  = raw_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      pay_r  <= '0;
      oob_r  <= '0;
      flag_r <= rfdt_pkg::OOB_FLAG_RESET;
      raw_r  <= '0;
    end else begin
      hdr_r  <= hdr_nxt;
      pay_r  <= pay_nxt;
      oob_r  <= oob_nxt;
      flag_r <= flag_nxt;
      raw_r  <= raw_nxt;
    end
  end

endmodule

/* tb/sv/rx_fabric_deframer_timestamp_tb.sv */
// Self-checking testbench for rx_fabric_deframer_timestamp: directed vectors and
// random frames, with every result beat checked against a predictor or a typed beat.
// Depends on rfdt_pkg and the rx_fabric_deframer_timestamp RTL only.
`timescale 1ns / 1ps

module rx_fabric_deframer_timestamp_tb;

  // Block configuration, taken from the package defaults the instance uses.
  localparam int HDR_LEN = rfdt_pkg::HEADER_BYTES_DEF;
  localparam int BUF_CAP = rfdt_pkg::MAX_PAYLOAD_BYTES_DEF;
  localparam longint ROLLBACK_TICKS = 3 * longint'(rfdt_pkg::REF_CLOCK_HZ_DEF) / 4;
  localparam longint NS_PER_TICK = rfdt_pkg::REF_PERIOD_PS_DEF / 1000;

  // Run control. The longest quiet stretch in a correct run is the result
  // hold-off below; the watchdog limit is well beyond it.
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS = 1000;
  localparam int PHASES = 10;

  localparam logic [39:0] T_SEC = 40'h00_1234_5678;
  localparam logic [29:0] T_NS = 30'd600000000;
  localparam logic [2:0] BUF_ADDR = {rfdt_pkg::REG_PAYLOAD_BUFFER, 2'b00};

  // How a directed vector is checked: from the predictor, as one beat typed
  // into the table, or as causing no beat at all.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_TYPED,
    CHK_SILENT
  } check_t;

  typedef struct packed {
    rfdt_pkg::item_t   word;
    check_t            mode;
    rfdt_pkg::result_t beat;
    logic              set_buf;
    logic [11:0]       buf_value;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_word_type;
  logic [15:0] in_word_data;
  logic        in_fifo_empty;
  logic [39:0] in_now_seconds;
  logic [29:0] in_now_nanoseconds;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_kind;
  logic [9:0]  out_word_index;
  logic [15:0] out_stored_word;
  logic [11:0] out_frame_bytes;
  logic [39:0] out_stamp_seconds;
  logic [30:0] out_stamp_nanoseconds;
  logic        out_stamp_ahead;
  logic        out_stamp_valid;
  logic        out_last_of_run;

  rx_fabric_deframer_timestamp i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_word_type          (in_word_type),
    .in_word_data          (in_word_data),
    .in_fifo_empty         (in_fifo_empty),
    .in_now_seconds        (in_now_seconds),
    .in_now_nanoseconds    (in_now_nanoseconds),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_kind       (out_result_kind),
    .out_word_index        (out_word_index),
    .out_stored_word       (out_stored_word),
    .out_frame_bytes       (out_frame_bytes),
    .out_stamp_seconds     (out_stamp_seconds),
    .out_stamp_nanoseconds (out_stamp_nanoseconds),
    .out_stamp_ahead       (out_stamp_ahead),
    .out_stamp_valid       (out_stamp_valid),
    .out_last_of_run       (out_last_of_run)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Result beats that the block still owes, oldest first.
  rfdt_pkg::result_t beats_due[$];
  bit failed = 1'b0;

  // When set, neither side idles.
  bit calm = 1'b0;
  // The stimulus asks for a long result hold-off by bumping holds_asked; the
  // result sink counts the stretch out on its own.
  int holds_asked = 0;
  // Words that did something in the block, i.e. not a leading status word.
  int busy_words = 0;

  // Predictor state: the deframer's view of the frame in progress.
  logic [11:0] cfg_buf_bytes = rfdt_pkg::BUF_BYTES_RESET;
  int unsigned hdr_bytes = 0;
  int unsigned pay_bytes = 0;
  int unsigned oob_words = 0;
  logic [15:0] oob_flags = rfdt_pkg::OOB_FLAG_RESET;
  logic [31:0] raw_stamp = '0;

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic rfdt_pkg::result_t store_beat(logic [1:0] kind, logic [9:0] idx,
                                                   logic [15:0] data);
    rfdt_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.word_index = idx;
    r.stored_word = data;
    return r;
  endfunction

  // A frame-done beat is always the last beat of its word.
  function automatic rfdt_pkg::result_t done_beat(logic [11:0] bytes, logic [39:0] sec,
                                                  logic [30:0] ns, logic ahead, logic ok);
    rfdt_pkg::result_t r;
    r = '0;
    r.result_kind = rfdt_pkg::KIND_DONE;
    r.frame_bytes = bytes;
    r.stamp_seconds = sec;
    r.stamp_nanoseconds = ns;
    r.stamp_ahead = ahead;
    r.stamp_valid = ok;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic int unsigned buffer_limit();
    return (cfg_buf_bytes < BUF_CAP) ? cfg_buf_bytes : BUF_CAP;
  endfunction

  // Builds the frame-done beat from the collected out-of-band words and the
  // current time, then clears the frame state.
  function automatic rfdt_pkg::result_t close_frame(logic [39:0] now_s, logic [29:0] now_ns);
    logic [27:0]       rise;
    logic [3:0]        fall;
    logic [3:0]        lag;
    logic [39:0]       sec;
    longint unsigned   ns;
    logic [11:0]       bytes;
    rfdt_pkg::result_t r;
    bytes = (pay_bytes < buffer_limit()) ? 12'(pay_bytes) : 12'(buffer_limit());
    if (oob_words != 0) begin
      rise = raw_stamp[27:0];
      fall = raw_stamp[31:28];
      sec = now_s;
      // The rising counter is late in its second while the clock is early in
      // the next one: the stamp belongs to the previous second, floor zero.
      if (longint'(rise) > ROLLBACK_TICKS && now_ns < rfdt_pkg::QUARTER_SEC_NS &&
          sec != '0) begin
        sec = sec - 40'd1;
      end
      ns = longint'(rise) * NS_PER_TICK;
      if (ns > rfdt_pkg::NS_MAX) begin
        ns = rfdt_pkg::NS_MAX;
      end
      lag = rise[3:0] - fall;
      r = done_beat(bytes, sec, ns[30:0], lag == 4'd1, !oob_flags[rfdt_pkg::TS_BAD_BIT]);
    end else begin
      r = done_beat(bytes, '0, '0, 1'b0, 1'b0);
    end
    hdr_bytes = 0;
    pay_bytes = 0;
    oob_words = 0;
    oob_flags = rfdt_pkg::OOB_FLAG_RESET;
    raw_stamp = '0;
    return r;
  endfunction

  // Advances the predictor by one word and returns how many beats it causes.
  function automatic int deframe_word(input rfdt_pkg::item_t w,
                                      output rfdt_pkg::result_t b0,
                                      output rfdt_pkg::result_t b1,
                                      output bit ignored);
    int n;
    bit done;
    rfdt_pkg::result_t fin;
    n = 0;
    done = 1'b0;
    ignored = 1'b0;
    b0 = '0;
    b1 = '0;
    if (oob_words != 0) begin
      // Inside the out-of-band run: anything else ends the frame and is lost.
      if (w.word_type == rfdt_pkg::WORD_OOB) begin
        if (oob_words == 1) begin
          raw_stamp = {w.word_data, 16'h0000};
          oob_words = 2;
        end else begin
          raw_stamp[15:0] = w.word_data;
          oob_words = 3;
          done = 1'b1;
        end
        done = done | w.fifo_empty;
      end else begin
        done = 1'b1;
      end
    end else if (w.word_type == rfdt_pkg::WORD_OOB) begin
      oob_flags = w.word_data;
      oob_words = 1;
      done = w.fifo_empty;
    end else begin
      if (w.word_type == rfdt_pkg::WORD_DATA && hdr_bytes < HDR_LEN) begin
        b0 = store_beat(rfdt_pkg::KIND_HEADER, 10'(hdr_bytes >> 1), w.word_data);
        n = 1;
        hdr_bytes += 2;
      end else if (w.word_type != rfdt_pkg::WORD_STATUS && pay_bytes >= buffer_limit()) begin
        pay_bytes = (pay_bytes + 2 > 65535) ? 65535 : pay_bytes + 2;
      end else if (w.word_type != rfdt_pkg::WORD_STATUS) begin
        b0 = store_beat(rfdt_pkg::KIND_PAYLOAD, 10'(pay_bytes >> 1), w.word_data);
        n = 1;
        pay_bytes += (w.word_type == rfdt_pkg::WORD_DATA) ? 2 : 1;
      end else if (hdr_bytes > 0) begin
        done = 1'b1;
      end else begin
        ignored = !w.fifo_empty;
      end
      done = done | w.fifo_empty;
    end
    if (done) begin
      fin = close_frame(w.now_seconds, w.now_nanoseconds);
      if (n == 0) begin
        b0 = fin;
      end else begin
        b1 = fin;
      end
      n++;
    end else if (n == 1) begin
      b0.last_of_run = 1'b1;
    end
    return n;
  endfunction

  function automatic rfdt_pkg::item_t make_word(logic [1:0] t, logic [15:0] d, logic e);
    rfdt_pkg::item_t w;
    w.word_type = t;
    w.word_data = d;
    w.fifo_empty = e;
    case ($urandom_range(3))
      0: w.now_seconds = '0;
      1: w.now_seconds = '1;
      default: w.now_seconds = {8'($urandom), 32'($urandom)};
    endcase
    case ($urandom_range(3))
      0: w.now_nanoseconds = '0;
      1: w.now_nanoseconds = 30'd999999999;
      2: w.now_nanoseconds = 30'($urandom_range(249999999));
      default: w.now_nanoseconds = 30'($urandom_range(999999999));
    endcase
    return w;
  endfunction

  function automatic vector_t vec(check_t mode, rfdt_pkg::result_t beat, logic [1:0] t,
                                  logic [15:0] d, logic e, logic [39:0] s = T_SEC,
                                  logic [29:0] ns = T_NS);
    vector_t v;
    v = '0;
    v.word.word_type = t;
    v.word.word_data = d;
    v.word.fifo_empty = e;
    v.word.now_seconds = s;
    v.word.now_nanoseconds = ns;
    v.mode = mode;
    v.beat = beat;
    v.beat.last_of_run = (mode == CHK_TYPED);
    return v;
  endfunction

  // Offers one beat on the input channel and returns at the edge that takes
  // it. The expected results are queued first; they cannot show up before the
  // word has passed the input register and the result queue anyway.
  task automatic send_word(input rfdt_pkg::item_t w, input check_t mode = CHK_PREDICT,
                           input rfdt_pkg::result_t typed = '0);
    rfdt_pkg::result_t b0;
    rfdt_pkg::result_t b1;
    int n;
    bit ignored;
    n = deframe_word(w, b0, b1, ignored);
    if (!ignored) begin
      busy_words++;
    end
    case (mode)
      CHK_PREDICT: begin
        if (n > 0) beats_due.push_back(b0);
        if (n > 1) beats_due.push_back(b1);
      end
      CHK_TYPED: beats_due.push_back(typed);
      default: ;
    endcase
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word_type <= w.word_type;
    in_word_data <= w.word_data;
    in_fifo_empty <= w.fifo_empty;
    in_now_seconds <= w.now_seconds;
    in_now_nanoseconds <= w.now_nanoseconds;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random words are sprinkled in between the well-formed ones.
  task automatic feed(input rfdt_pkg::item_t w);
    if ($urandom_range(99) < 6) begin
      send_word(make_word(2'($urandom_range(3)), 16'($urandom), $urandom_range(9) == 0));
    end
    send_word(w);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the block drain, then writes the buffer size and reads it back.
  task automatic set_buffer_size(input logic [11:0] value);
    logic [31:0] rd;
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BUF_ADDR;
    pwdata <= {20'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_buf_bytes = value;
    @(posedge clk);
    apb_read(BUF_ADDR, rd);
    check_field("payload_buffer_bytes", value, rd[11:0]);
  endtask

  // One frame with random content: optional leading status, header words,
  // payload words, then one of the ways a frame can end.
  task automatic send_frame();
    int nh;
    int np;
    if ($urandom_range(1)) feed(make_word(rfdt_pkg::WORD_STATUS, 16'($urandom), 1'b0));
    nh = ($urandom_range(3) == 0) ? $urandom_range(9) : 7;
    np = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(10);
    repeat (nh) feed(make_word(rfdt_pkg::WORD_DATA, 16'($urandom), 1'b0));
    repeat (np) begin
      feed(make_word(($urandom_range(9) < 3) ? rfdt_pkg::WORD_BSEL : rfdt_pkg::WORD_DATA,
                     16'($urandom), 1'b0));
    end
    case ($urandom_range(6))
      0, 1: begin
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b0));
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b0));
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'($urandom_range(1))));
      end
      2: feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b1));
      3: begin
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b0));
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b1));
      end
      4: feed(make_word(rfdt_pkg::WORD_STATUS, 16'($urandom), 1'b0));
      5: feed(make_word(rfdt_pkg::WORD_DATA, 16'($urandom), 1'b1));
      default: begin
        // Broken out-of-band run: cut short by an ordinary word.
        feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b0));
        if ($urandom_range(1)) feed(make_word(rfdt_pkg::WORD_OOB, 16'($urandom), 1'b0));
        send_word(make_word(($urandom_range(1)) ? rfdt_pkg::WORD_STATUS : rfdt_pkg::WORD_BSEL,
                            16'($urandom), 1'($urandom_range(1))));
      end
    endcase
  endtask

  // Result sink: checks every accepted beat against the oldest expectation
  // and drives out_ready, including the long hold-off that backs the block up.
  initial begin : result_sink
    rfdt_pkg::result_t want;
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          $error("result beat of kind %0d with nothing expected", out_result_kind);
          failed = 1'b1;
        end else begin
          want = beats_due.pop_front();
          check_field("result_kind", want.result_kind, out_result_kind);
          check_field("word_index", want.word_index, out_word_index);
          check_field("stored_word", want.stored_word, out_stored_word);
          check_field("frame_bytes", want.frame_bytes, out_frame_bytes);
          check_field("stamp_seconds", want.stamp_seconds, out_stamp_seconds);
          check_field("stamp_nanoseconds", want.stamp_nanoseconds, out_stamp_nanoseconds);
          check_field("stamp_ahead", want.stamp_ahead, out_stamp_ahead);
          check_field("stamp_valid", want.stamp_valid, out_stamp_valid);
          check_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // Watchdog: a run that stops moving beats on both channels is a failure.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t     directed[$];
    vector_t     v;
    logic [31:0] rd;
    logic [11:0] phase_buf[PHASES];
    int          phase_end;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_word_type = rfdt_pkg::WORD_DATA;
    in_word_data = '0;
    in_fifo_empty = 1'b0;
    in_now_seconds = '0;
    in_now_nanoseconds = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The buffer size comes out of reset at its documented value.
    apb_read(BUF_ADDR, rd);
    check_field("payload_buffer_bytes", rfdt_pkg::BUF_BYTES_RESET, rd[11:0]);

    // Directed vectors. Header words start at index zero; byte-select words
    // go straight to the payload even before the header is complete.
    directed.push_back(vec(CHK_SILENT, '0, rfdt_pkg::WORD_STATUS, 16'h0000, 1'b0));
    directed.push_back(vec(CHK_TYPED, store_beat(rfdt_pkg::KIND_HEADER, 10'd0, 16'h0000),
                           rfdt_pkg::WORD_DATA, 16'h0000, 1'b0));
    directed.push_back(vec(CHK_TYPED, store_beat(rfdt_pkg::KIND_HEADER, 10'd1, 16'hFFFF),
                           rfdt_pkg::WORD_DATA, 16'hFFFF, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_BSEL, 16'h00FF, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_BSEL, 16'hFF00, 1'b0));
    // Full out-of-band run with all-ones stamp at the top of the seconds
    // range, just after a second boundary: seconds roll back by one.
    directed.push_back(vec(CHK_SILENT, '0, rfdt_pkg::WORD_OOB, 16'h0000, 1'b0));
    directed.push_back(vec(CHK_SILENT, '0, rfdt_pkg::WORD_OOB, 16'hFFFF, 1'b0));
    directed.push_back(vec(CHK_TYPED,
                           done_beat(12'd2, 40'hFF_FFFF_FFFE, 31'd2147483640, 1'b0, 1'b1),
                           rfdt_pkg::WORD_OOB, 16'hFFFF, 1'b0, '1, '0));
    // Empty FIFO on a fresh frame ends it with nothing delivered.
    directed.push_back(vec(CHK_TYPED, done_beat('0, '0, '0, 1'b0, 1'b0),
                           rfdt_pkg::WORD_STATUS, 16'h0000, 1'b1));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_DATA, 16'h1111, 1'b1));
    // Status after a header word ends the frame.
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_DATA, 16'h2222, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_STATUS, 16'h0000, 1'b0));
    // Lone flag word marking the stamp bad, ended by the empty FIFO.
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0800, 1'b1, T_SEC,
                           30'd999999999));
    // Falling counter one behind the rising counter.
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0000, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h2005, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0003, 1'b0, T_SEC,
                           30'd999999999));
    // Rollback requested while the seconds are already zero.
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'hF7FF, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0FFF, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'hFFFF, 1'b0, '0, '0));
    // Out-of-band run cut short by a status word, then by the empty FIFO.
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0800, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_STATUS, 16'hFFFF, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0000, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h1234, 1'b1));
    // Zero-byte buffer: payload is counted but never stored.
    v = vec(CHK_SILENT, '0, rfdt_pkg::WORD_BSEL, 16'hABCD, 1'b0);
    v.set_buf = 1'b1;
    v.buf_value = 12'd0;
    directed.push_back(v);
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_DATA, 16'h8001, 1'b1));
    // Two-byte buffer fills up after two byte-select words.
    v = vec(CHK_PREDICT, '0, rfdt_pkg::WORD_BSEL, 16'h0101, 1'b0);
    v.set_buf = 1'b1;
    v.buf_value = 12'd2;
    directed.push_back(v);
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_BSEL, 16'h0202, 1'b0));
    directed.push_back(vec(CHK_SILENT, '0, rfdt_pkg::WORD_BSEL, 16'h0303, 1'b0));
    directed.push_back(vec(CHK_PREDICT, '0, rfdt_pkg::WORD_OOB, 16'h0000, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].set_buf) set_buffer_size(directed[i].buf_value);
      send_word(directed[i].word, directed[i].mode, directed[i].beat);
    end

    // Random frames over a spread of buffer sizes, mostly small so that the
    // buffer-full path is hit often. One phase stalls the result side for a
    // long stretch, another runs without any idling.
    phase_buf = '{12'd0, 12'd1, 12'd4095, 12'd3, 12'd2048, 12'd8, 12'd0,
                  12'd2047, 12'd1536, 12'd24};
    phase_buf[6] = 12'($urandom_range(2048));
    busy_words = 0;
    for (int p = 0; p < PHASES; p++) begin
      set_buffer_size(phase_buf[p]);
      calm = (p == 5);
      if (p == 2) holds_asked++;
      phase_end = (p + 1) * RANDOM_WORDS / PHASES;
      while (busy_words < phase_end) send_frame();
    end
    calm = 1'b0;

    // Drain: every expected beat must arrive, then nothing more may follow.
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (!failed && beats_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
